// ===== hdl/bqf_pkg.sv =====
// ----------------------------------------------------------------------------
// bqf_pkg: shared types and constants for the biquad low-pass filter
// Field widths, fixed-point formats, register map and reset values.
// ----------------------------------------------------------------------------
package bqf_pkg;

    // Field widths
    localparam int SAMPLE_W = 32;   // signed Q16.16
    localparam int COEF_W   = 32;   // signed Q2.30
    localparam int SCALE_W  = 48;   // unsigned Q32.16

    // Fraction bits dropped when narrowing
    localparam int COEF_FRAC  = 30;
    localparam int SCALE_FRAC = 16;

    // Configuration port
    localparam int CFG_DATA_W  = 64;
    localparam int CFG_ADDR_W  = 6;
    localparam int CFG_IDX_LSB = 3;
    localparam int CFG_IDX_W   = 3;

    // Register reset values
    localparam logic [COEF_W-1:0]  COEF_ONE  = 32'h4000_0000;
    localparam logic [SCALE_W-1:0] SCALE_ONE = 48'h0000_0001_0000;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [COEF_W-1:0]   coef_t;

    // Register index (byte address / 8)
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_B0    = 3'd0,
        REG_B1    = 3'd1,
        REG_B2    = 3'd2,
        REG_A1    = 3'd3,
        REG_A2    = 3'd4,
        REG_SCALE = 3'd5
    } cfg_reg_t;

endpackage

// ===== hdl/bqf_in_if.sv =====
// ----------------------------------------------------------------------------
// bqf_in_if: input request channel of the biquad filter
// Valid/ready handshake carrying the command and the input sample.
// ----------------------------------------------------------------------------
interface bqf_in_if
    import bqf_pkg::*;
();

    logic    valid;
    logic    ready;
    logic    cmd;
    sample_t sample;

    modport source (output valid, output cmd, output sample, input ready);
    modport sink   (input valid, input cmd, input sample, output ready);

endinterface

// ===== hdl/bqf_out_if.sv =====
// ----------------------------------------------------------------------------
// bqf_out_if: result request channel of the biquad filter
// Valid/ready handshake carrying the filtered sample and warm-up flag.
// ----------------------------------------------------------------------------
interface bqf_out_if
    import bqf_pkg::*;
();

    logic    valid;
    logic    ready;
    sample_t filtered;
    logic    warming_up;

    modport source (output valid, output filtered, output warming_up, input ready);
    modport sink   (input valid, input filtered, input warming_up, output ready);

endinterface

// ===== hdl/bqf_serial_mul.sv =====
// ----------------------------------------------------------------------------
// bqf_serial_mul: bit-serial signed multiplier
// Consumes the serial operand one bit per cycle from a shift register and
// adds the parallel operand into a right-shifting partial product.
// ----------------------------------------------------------------------------
module bqf_serial_mul
    import bqf_pkg::*;
#(
    parameter int PAR_W = 49
)(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic signed [COEF_W-1:0]   ser_in,
    input  logic signed [PAR_W-1:0]    par_in,
    output logic                       done,
    output logic signed [PAR_W+COEF_W:0] product
);

    localparam int CNT_W = $clog2(COEF_W);

    logic signed [PAR_W:0]   hi_reg;
    logic        [COEF_W-1:0] lo_reg;
    logic signed [PAR_W-1:0] b_reg;
    logic [CNT_W-1:0]        cnt_reg;
    logic                    busy_reg;
    logic                    done_reg;

    logic                    last_bit;
    logic signed [PAR_W:0]   b_ext;
    logic signed [PAR_W:0]   addend;
    logic signed [PAR_W:0]   sum;

    // Partial product step; the sign bit of the serial operand weighs negative
    always_comb
    begin
        last_bit = (cnt_reg == CNT_W'(COEF_W - 1));
        b_ext    = {b_reg[PAR_W-1], b_reg};
        if (!lo_reg[0])
            addend = '0;
        else if (last_bit)
            addend = -b_ext;
        else
            addend = b_ext;
        sum = hi_reg + addend;
    end

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + CNT_W'(1);
            if (last_bit)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // Datapath shift registers
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            hi_reg <= '0;
            lo_reg <= ser_in;
            b_reg  <= par_in;
        end
        else if (busy_reg)
        begin
            hi_reg <= {sum[PAR_W], sum[PAR_W:1]};
            lo_reg <= {sum[0], lo_reg[COEF_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = {hi_reg, lo_reg};

endmodule

// ===== hdl/biquad_lowpass_filter.sv =====
// ----------------------------------------------------------------------------
// biquad_lowpass_filter: second-order direct form II low-pass biquad
// Q16.16 samples, Q2.30 coefficients, one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
//  channel   dir  handshake          payload
//  din       in   valid / ready      cmd, sample
//  dout      out  valid / ready      filtered, warming_up
//  apb       in   psel/penable/...   paddr, pwdata, prdata (8-byte stride)
//
//  Each product runs through the 32-step bit-serial multiplier, five per
//  request plus one more for the preload. One request is in work at a
//  time; the next is accepted while a result still waits in the output
//  register, and work stalls at the end until it is taken. Reset clears
//  the delays and warm-up count, sets b0 and the scale register to one and
//  clears the other coefficients.
// ----------------------------------------------------------------------------
module biquad_lowpass_filter
    import bqf_pkg::*;
#(
    parameter int WARMUP_SAMPLES = 5,
    parameter int DELAY_WIDTH    = 48
)(
    input  logic                  clk,
    input  logic                  rst_n,
    bqf_in_if.sink                din,
    bqf_out_if.source             dout,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int PAR_W  = ((DELAY_WIDTH > SCALE_W) ? DELAY_WIDTH : SCALE_W) + 1;
    localparam int PROD_W = PAR_W + COEF_W + 1;
    localparam int ACC_W  = PROD_W + 2;
    localparam int WC_W   = (WARMUP_SAMPLES > 0) ? $clog2(WARMUP_SAMPLES + 1) : 1;

    localparam logic signed [ACC_W-1:0] HALF_COEF =
        {{(ACC_W-COEF_FRAC){1'b0}}, 1'b1, {(COEF_FRAC-1){1'b0}}};
    localparam logic signed [ACC_W-1:0] HALF_SCALE =
        {{(ACC_W-SCALE_FRAC){1'b0}}, 1'b1, {(SCALE_FRAC-1){1'b0}}};

    typedef enum logic [2:0] {
        S_IDLE,
        S_START,
        S_MUL,
        S_ACC,
        S_NARROW_W,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        ST_PRE,
        ST_A1,
        ST_A2,
        ST_B0,
        ST_B1,
        ST_B2
    } step_t;

    // Saturate a rounded accumulator to the delay width
    function automatic logic [DELAY_WIDTH-1:0] sat_delay(input logic [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:DELAY_WIDTH-1]) || !(|v[ACC_W-1:DELAY_WIDTH-1]);
        if (fits)
            return v[DELAY_WIDTH-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(DELAY_WIDTH-1){1'b0}}};
        else
            return {1'b0, {(DELAY_WIDTH-1){1'b1}}};
    endfunction

    // Saturate a rounded accumulator to the sample width
    function automatic logic [SAMPLE_W-1:0] sat_out(input logic [ACC_W-1:0] v);
        logic fits;
        fits = (&v[ACC_W-1:SAMPLE_W-1]) || !(|v[ACC_W-1:SAMPLE_W-1]);
        if (fits)
            return v[SAMPLE_W-1:0];
        else if (v[ACC_W-1])
            return {1'b1, {(SAMPLE_W-1){1'b0}}};
        else
            return {1'b0, {(SAMPLE_W-1){1'b1}}};
    endfunction

    // Configuration registers
    coef_t              coef_b0_reg, coef_b1_reg, coef_b2_reg, coef_a1_reg, coef_a2_reg;
    logic [SCALE_W-1:0] reset_scale_reg;

    // Engine state
    state_t                        state_reg;
    step_t                         step_reg;
    sample_t                       x_reg;
    logic signed [ACC_W-1:0]       acc_reg;
    logic signed [DELAY_WIDTH-1:0] delay_one_reg, delay_two_reg, w0_reg;
    logic [WC_W-1:0]               warm_cnt_reg;
    logic                          out_valid_reg;
    sample_t                       filtered_reg;
    logic                          warming_reg;

    // Multiplier hookup
    logic                     mul_start;
    logic                     mul_done;
    logic signed [COEF_W-1:0] mul_ser;
    logic signed [PAR_W-1:0]  mul_par;
    logic signed [PROD_W-1:0] mul_prod;

    logic                     in_accept;
    logic                     cfg_we;
    logic                     cfg_hit;
    logic [CFG_IDX_W-1:0]     cfg_idx;
    logic signed [ACC_W-1:0]  prod_ext;
    logic signed [ACC_W-1:0]  x_acc;
    logic signed [ACC_W-1:0]  pre_shifted;
    logic signed [ACC_W-1:0]  acc_shifted;
    logic [DELAY_WIDTH-1:0]   pre_sat;
    logic [DELAY_WIDTH-1:0]   w0_sat;
    logic [SAMPLE_W-1:0]      y_sat;
    logic                     warm;

    // Handshake and register decode
    assign in_accept = din.valid && din.ready;
    assign din.ready = (state_reg == S_IDLE);
    assign cfg_we    = psel && penable && pwrite;
    assign cfg_idx   = paddr[CFG_IDX_LSB+CFG_IDX_W-1:CFG_IDX_LSB];
    assign cfg_hit   = (cfg_idx <= REG_SCALE);
    assign pready    = 1'b1;

    // Configuration write
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_b0_reg     <= COEF_ONE;
            coef_b1_reg     <= '0;
            coef_b2_reg     <= '0;
            coef_a1_reg     <= '0;
            coef_a2_reg     <= '0;
            reset_scale_reg <= SCALE_ONE;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_idx))
                REG_B0:    coef_b0_reg     <= pwdata[COEF_W-1:0];
                REG_B1:    coef_b1_reg     <= pwdata[COEF_W-1:0];
                REG_B2:    coef_b2_reg     <= pwdata[COEF_W-1:0];
                REG_A1:    coef_a1_reg     <= pwdata[COEF_W-1:0];
                REG_A2:    coef_a2_reg     <= pwdata[COEF_W-1:0];
                REG_SCALE: reset_scale_reg <= pwdata[SCALE_W-1:0];
                default:   ;
            endcase
        end
    end

    // Register read-back
    always_comb
    begin
        unique case (cfg_reg_t'(cfg_idx))
            REG_B0:    prdata = {{(CFG_DATA_W-COEF_W){1'b0}}, coef_b0_reg};
            REG_B1:    prdata = {{(CFG_DATA_W-COEF_W){1'b0}}, coef_b1_reg};
            REG_B2:    prdata = {{(CFG_DATA_W-COEF_W){1'b0}}, coef_b2_reg};
            REG_A1:    prdata = {{(CFG_DATA_W-COEF_W){1'b0}}, coef_a1_reg};
            REG_A2:    prdata = {{(CFG_DATA_W-COEF_W){1'b0}}, coef_a2_reg};
            REG_SCALE: prdata = {{(CFG_DATA_W-SCALE_W){1'b0}}, reset_scale_reg};
            default:   prdata = '0;
        endcase
    end

    // Operand select for the current product
    always_comb
    begin
        unique case (step_reg)
            ST_PRE:
            begin
                mul_ser = x_reg;
                mul_par = {{(PAR_W-SCALE_W){1'b0}}, reset_scale_reg};
            end
            ST_A1:
            begin
                mul_ser = coef_a1_reg;
                mul_par = {{(PAR_W-DELAY_WIDTH){delay_one_reg[DELAY_WIDTH-1]}}, delay_one_reg};
            end
            ST_A2:
            begin
                mul_ser = coef_a2_reg;
                mul_par = {{(PAR_W-DELAY_WIDTH){delay_two_reg[DELAY_WIDTH-1]}}, delay_two_reg};
            end
            ST_B0:
            begin
                mul_ser = coef_b0_reg;
                mul_par = {{(PAR_W-DELAY_WIDTH){w0_reg[DELAY_WIDTH-1]}}, w0_reg};
            end
            ST_B1:
            begin
                mul_ser = coef_b1_reg;
                mul_par = {{(PAR_W-DELAY_WIDTH){delay_one_reg[DELAY_WIDTH-1]}}, delay_one_reg};
            end
            ST_B2:
            begin
                mul_ser = coef_b2_reg;
                mul_par = {{(PAR_W-DELAY_WIDTH){delay_two_reg[DELAY_WIDTH-1]}}, delay_two_reg};
            end
            default:
            begin
                mul_ser = coef_b2_reg;
                mul_par = {{(PAR_W-DELAY_WIDTH){delay_two_reg[DELAY_WIDTH-1]}}, delay_two_reg};
            end
        endcase
    end

    assign mul_start = (state_reg == S_START);

    bqf_serial_mul #(
        .PAR_W (PAR_W)
    ) u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .ser_in  (mul_ser),
        .par_in  (mul_par),
        .done    (mul_done),
        .product (mul_prod)
    );

    // Rounding (add half, arithmetic shift) and saturation
    always_comb
    begin
        prod_ext    = {{(ACC_W-PROD_W){mul_prod[PROD_W-1]}}, mul_prod};
        x_acc       = {{(ACC_W-SAMPLE_W-COEF_FRAC){din.sample[SAMPLE_W-1]}},
                       din.sample, {COEF_FRAC{1'b0}}};
        pre_shifted = (prod_ext + HALF_SCALE) >>> SCALE_FRAC;
        acc_shifted = (acc_reg + HALF_COEF) >>> COEF_FRAC;
        pre_sat     = sat_delay(pre_shifted);
        w0_sat      = sat_delay(acc_shifted);
        y_sat       = sat_out(acc_shifted);
        warm        = (warm_cnt_reg < WC_W'(WARMUP_SAMPLES));
    end

    // Sequencer, delays and output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= ST_A1;
            x_reg         <= '0;
            acc_reg       <= '0;
            w0_reg        <= '0;
            delay_one_reg <= '0;
            delay_two_reg <= '0;
            warm_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
            filtered_reg  <= '0;
            warming_reg   <= 1'b0;
        end
        else
        begin
            if (dout.valid && dout.ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_accept)
                    begin
                        x_reg     <= din.sample;
                        acc_reg   <= x_acc;
                        step_reg  <= din.cmd ? ST_PRE : ST_A1;
                        state_reg <= S_START;
                    end
                end
                S_START:
                begin
                    state_reg <= S_MUL;
                end
                S_MUL:
                begin
                    if (mul_done)
                        state_reg <= S_ACC;
                end
                S_ACC:
                begin
                    case (step_reg)
                        ST_PRE:
                        begin
                            delay_one_reg <= pre_sat;
                            delay_two_reg <= pre_sat;
                            step_reg      <= ST_A1;
                            state_reg     <= S_START;
                        end
                        ST_A1:
                        begin
                            acc_reg   <= acc_reg - prod_ext;
                            step_reg  <= ST_A2;
                            state_reg <= S_START;
                        end
                        ST_A2:
                        begin
                            acc_reg   <= acc_reg - prod_ext;
                            state_reg <= S_NARROW_W;
                        end
                        ST_B0:
                        begin
                            acc_reg   <= acc_reg + prod_ext;
                            step_reg  <= ST_B1;
                            state_reg <= S_START;
                        end
                        ST_B1:
                        begin
                            acc_reg   <= acc_reg + prod_ext;
                            step_reg  <= ST_B2;
                            state_reg <= S_START;
                        end
                        default:
                        begin
                            acc_reg   <= acc_reg + prod_ext;
                            state_reg <= S_DONE;
                        end
                    endcase
                end
                S_NARROW_W:
                begin
                    w0_reg    <= w0_sat;
                    acc_reg   <= '0;
                    step_reg  <= ST_B0;
                    state_reg <= S_START;
                end
                S_DONE:
                begin
                    // Wait until the output register is free
                    if (!out_valid_reg || dout.ready)
                    begin
                        delay_two_reg <= delay_one_reg;
                        delay_one_reg <= w0_reg;
                        out_valid_reg <= 1'b1;
                        if (warm)
                        begin
                            filtered_reg <= x_reg;
                            warming_reg  <= 1'b1;
                            warm_cnt_reg <= warm_cnt_reg + WC_W'(1);
                        end
                        else
                        begin
                            filtered_reg <= y_sat;
                            warming_reg  <= 1'b0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            // A write to a mapped register clears the delays
            if (cfg_we && cfg_hit)
            begin
                delay_one_reg <= '0;
                delay_two_reg <= '0;
            end
        end
    end

    assign dout.valid      = out_valid_reg;
    assign dout.filtered   = filtered_reg;
    assign dout.warming_up = warming_reg;

`ifndef SYNTH
    // Multiplier finishes only while the sequencer waits for it
    a_mul_done_in_mul: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == S_MUL))
        else $error("multiplier done outside of multiply state");

    // A new result only comes out of the final step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(dout.valid) |-> $past(state_reg == S_DONE))
        else $error("result raised outside of final step");

    // Warm-up counter saturates
    a_warm_bound: assert property (@(posedge clk) disable iff (!rst_n)
        warm_cnt_reg <= WC_W'(WARMUP_SAMPLES))
        else $error("warm-up counter past its limit");

    // A write to a mapped register leaves both delays cleared
    a_cfg_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_we && cfg_hit) |=> (delay_one_reg == '0 && delay_two_reg == '0))
        else $error("delays not cleared by register write");
`endif

endmodule
